>>> hw/rtl/fsrm_pkg.sv
// Shared types, codes and constants of the flash slot rotation manager.
package fsrm_pkg;

    // Record slots in each of the two sectors.
    localparam int SLOTS = 16;
    localparam int SLOT_W = $clog2(SLOTS);
    // Target slot carries one extra code, SLOTS, for "no slot used yet".
    localparam int TSLOT_W = 5;
    localparam int PROBE_BUDGET = 2 * SLOTS;
    localparam int PROBE_W = $clog2(PROBE_BUDGET + 1);
    localparam int LIMIT_W = 6;
    localparam int SEQ_W = 32;
    localparam int FAIL_W = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 6;

    localparam logic [LIMIT_W-1:0] ATTEMPT_LIMIT_RST = 6'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ATTEMPT_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FORCE_DEFAULTS = 1'd1;

    typedef enum logic [1:0] {
        MODE_SCAN_REPORT = 2'd0,
        MODE_SCAN_DONE   = 2'd1,
        MODE_SAVE_REQ    = 2'd2,
        MODE_WRITE_DONE  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        KIND_ACK         = 3'd0,
        KIND_SCAN_RESULT = 3'd1,
        KIND_PROGRAM     = 3'd2,
        KIND_SAVE_DONE   = 3'd3,
        KIND_SAVE_FAILED = 3'd4
    } kind_t;

    typedef struct packed {
        mode_t              mode;
        logic               sector;
        logic [3:0]         slot;
        logic               magic_ok;
        logic               check_ok;
        logic [SEQ_W-1:0]   seq_in;
        logic               prog_ok;
    } in_item_t;

    typedef struct packed {
        kind_t              kind;
        logic               tgt_sector;
        logic [TSLOT_W-1:0] target_slot;
        logic               erase_first;
        logic [SEQ_W-1:0]   seq_out;
        logic               fresh_start;
        logic [FAIL_W-1:0]  fail_count;
    } out_item_t;

    // Controller to datapath.
    typedef struct packed {
        logic capture;   // latch the accepted input transaction
        logic exec;      // carry out the captured item
        logic step;      // one probe step of the slot walk
        logic out_load;  // load the result into the output register
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic go_probe;     // captured item needs a slot walk
        logic probe_emits;  // current probe step ends the walk
    } status_t;

endpackage

>>> hw/rtl/fsrm_ctrl.sv
// Controller state machine and output valid of the flash slot rotation manager.
module fsrm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    input  fsrm_pkg::status_t status,
    output fsrm_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_EXEC  = 3'b010,
        ST_PROBE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        cmd.capture  = 1'b0;
        cmd.exec     = 1'b0;
        cmd.step     = 1'b0;
        cmd.out_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // hold until the output register can take a result
                if (out_free)
                begin
                    cmd.exec     = 1'b1;
                    cmd.out_load = !status.go_probe;
                    state_next   = status.go_probe ? ST_PROBE : ST_IDLE;
                end
            end
            ST_PROBE:
            begin
                if (out_free || !status.probe_emits)
                begin
                    cmd.step     = 1'b1;
                    cmd.out_load = status.probe_emits;
                    if (status.probe_emits)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> hw/rtl/fsrm_datapath.sv
// Datapath of the flash slot rotation manager: slot state, bad maps and result register.
module fsrm_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fsrm_pkg::cmd_t                      cmd,
    output fsrm_pkg::status_t                   status,
    input  fsrm_pkg::in_item_t                  in_data,
    output fsrm_pkg::out_item_t                 out_data,
    input  logic                                cfg_wr_en,
    input  logic [fsrm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fsrm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int SW = fsrm_pkg::SLOT_W;
    localparam int TW = fsrm_pkg::TSLOT_W;

    fsrm_pkg::in_item_t                  item_reg;
    fsrm_pkg::out_item_t                 out_data_reg;
    fsrm_pkg::out_item_t                 res;

    logic [fsrm_pkg::LIMIT_W-1:0]        attempt_limit_reg, attempt_limit_next;
    logic                                force_defaults_reg, force_defaults_next;
    logic [1:0][fsrm_pkg::SLOTS-1:0]     bad_map_reg, bad_map_next;
    logic                                cur_sector_reg, cur_sector_next;
    logic [TW-1:0]                       cur_slot_reg, cur_slot_next;
    logic                                tgt_sector_reg, tgt_sector_next;
    logic [TW-1:0]                       tgt_slot_reg, tgt_slot_next;
    logic [fsrm_pkg::SEQ_W-1:0]          best_seq_reg, best_seq_next;
    logic                                found_valid_reg, found_valid_next;
    logic [fsrm_pkg::SEQ_W-1:0]          record_seq_reg, record_seq_next;
    logic [fsrm_pkg::LIMIT_W-1:0]        attempts_used_reg, attempts_used_next;
    logic [fsrm_pkg::PROBE_W-1:0]        probes_used_reg, probes_used_next;
    logic [fsrm_pkg::FAIL_W-1:0]         fails_reg, fails_next;
    logic                                save_pending_reg, save_pending_next;
    logic                                erase_reg, erase_next;

    // probe step signals
    logic                                can_probe;
    logic [TW-1:0]                       walk_slot;
    logic                                wrap;
    logic                                walk_sector;
    logic [SW-1:0]                       walk_idx;
    logic                                walk_hit;
    logic                                need;

    assign can_probe   = (attempts_used_reg < attempt_limit_reg)
                      && (probes_used_reg < fsrm_pkg::PROBE_W'(fsrm_pkg::PROBE_BUDGET));
    assign walk_slot   = tgt_slot_reg + TW'(1);
    assign wrap        = (walk_slot >= TW'(fsrm_pkg::SLOTS));
    assign walk_sector = wrap ? !cur_sector_reg : tgt_sector_reg;
    assign walk_idx    = wrap ? '0 : walk_slot[SW-1:0];
    // a freshly cleared sector has no bad slot
    assign walk_hit    = !wrap && bad_map_reg[walk_sector][walk_idx];
    assign need        = !found_valid_reg || force_defaults_reg;

    assign status.go_probe = (item_reg.mode == fsrm_pkg::MODE_SAVE_REQ)
                          || ((item_reg.mode == fsrm_pkg::MODE_WRITE_DONE)
                              && save_pending_reg && !item_reg.prog_ok);
    assign status.probe_emits = !can_probe || !walk_hit;

    assign out_data = out_data_reg;

    always_comb
    begin
        attempt_limit_next  = attempt_limit_reg;
        force_defaults_next = force_defaults_reg;
        bad_map_next        = bad_map_reg;
        cur_sector_next     = cur_sector_reg;
        cur_slot_next       = cur_slot_reg;
        tgt_sector_next     = tgt_sector_reg;
        tgt_slot_next       = tgt_slot_reg;
        best_seq_next       = best_seq_reg;
        found_valid_next    = found_valid_reg;
        record_seq_next     = record_seq_reg;
        attempts_used_next  = attempts_used_reg;
        probes_used_next    = probes_used_reg;
        fails_next          = fails_reg;
        save_pending_next   = save_pending_reg;
        erase_next          = erase_reg;
        res                 = '0;
        res.kind            = fsrm_pkg::KIND_ACK;

        if (cfg_wr_en)
        begin
            case (cfg_index)
                fsrm_pkg::CFG_ATTEMPT_LIMIT:
                begin
                    attempt_limit_next = cfg_data[fsrm_pkg::LIMIT_W-1:0];
                end
                fsrm_pkg::CFG_FORCE_DEFAULTS:
                begin
                    force_defaults_next = cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.exec)
        begin
            case (item_reg.mode)
                fsrm_pkg::MODE_SCAN_REPORT:
                begin
                    if ((TW'(item_reg.slot) < TW'(fsrm_pkg::SLOTS)) && item_reg.magic_ok)
                    begin
                        if (item_reg.check_ok)
                        begin
                            // later report wins a tie
                            if (!found_valid_reg || (item_reg.seq_in >= best_seq_reg))
                            begin
                                best_seq_next    = item_reg.seq_in;
                                record_seq_next  = item_reg.seq_in;
                                cur_sector_next  = item_reg.sector;
                                cur_slot_next    = TW'(item_reg.slot);
                                found_valid_next = 1'b1;
                            end
                        end
                        else
                        begin
                            bad_map_next[item_reg.sector][SW'(item_reg.slot)] = 1'b1;
                        end
                    end
                    res.kind        = fsrm_pkg::KIND_ACK;
                    res.tgt_sector  = cur_sector_next;
                    res.target_slot = cur_slot_next;
                end
                fsrm_pkg::MODE_SCAN_DONE:
                begin
                    // fall back to factory state
                    if (need)
                    begin
                        cur_sector_next = 1'b0;
                        cur_slot_next   = TW'(fsrm_pkg::SLOTS);
                        record_seq_next = '0;
                    end
                    force_defaults_next = 1'b0;
                    found_valid_next    = 1'b0;
                    best_seq_next       = '0;
                    res.kind            = fsrm_pkg::KIND_SCAN_RESULT;
                    res.tgt_sector      = cur_sector_next;
                    res.target_slot     = cur_slot_next;
                    res.fresh_start     = need;
                end
                fsrm_pkg::MODE_SAVE_REQ:
                begin
                    record_seq_next    = record_seq_reg + fsrm_pkg::SEQ_W'(1);
                    save_pending_next  = 1'b1;
                    attempts_used_next = '0;
                    probes_used_next   = '0;
                    tgt_sector_next    = cur_sector_reg;
                    tgt_slot_next      = cur_slot_reg;
                    erase_next         = 1'b0;
                end
                fsrm_pkg::MODE_WRITE_DONE:
                begin
                    if (!save_pending_reg)
                    begin
                        res.kind        = fsrm_pkg::KIND_ACK;
                        res.tgt_sector  = cur_sector_reg;
                        res.target_slot = cur_slot_reg;
                    end
                    else
                    begin
                        cur_sector_next = tgt_sector_reg;
                        cur_slot_next   = tgt_slot_reg;
                        if (item_reg.prog_ok)
                        begin
                            save_pending_next = 1'b0;
                            fails_next        = '0;
                            res.kind          = fsrm_pkg::KIND_SAVE_DONE;
                            res.tgt_sector    = tgt_sector_reg;
                            res.target_slot   = tgt_slot_reg;
                        end
                        else
                        begin
                            // mark the slot bad and walk on
                            if (tgt_slot_reg < TW'(fsrm_pkg::SLOTS))
                            begin
                                bad_map_next[tgt_sector_reg][tgt_slot_reg[SW-1:0]] = 1'b1;
                            end
                            erase_next = 1'b0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.step)
        begin
            if (!can_probe)
            begin
                save_pending_next = 1'b0;
                if (fails_reg != '1)
                begin
                    fails_next = fails_reg + fsrm_pkg::FAIL_W'(1);
                end
                res.kind        = fsrm_pkg::KIND_SAVE_FAILED;
                res.tgt_sector  = cur_sector_reg;
                res.target_slot = cur_slot_reg;
            end
            else
            begin
                probes_used_next = probes_used_reg + fsrm_pkg::PROBE_W'(1);
                if (wrap)
                begin
                    bad_map_next[walk_sector] = '0;
                    erase_next                = 1'b1;
                end
                tgt_sector_next = walk_sector;
                tgt_slot_next   = TW'(walk_idx);
                if (!walk_hit)
                begin
                    attempts_used_next = attempts_used_reg + fsrm_pkg::LIMIT_W'(1);
                    res.kind           = fsrm_pkg::KIND_PROGRAM;
                    res.tgt_sector     = walk_sector;
                    res.target_slot    = TW'(walk_idx);
                    res.erase_first    = erase_reg || wrap;
                end
            end
        end

        res.seq_out    = record_seq_next;
        res.fail_count = fails_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attempt_limit_reg  <= fsrm_pkg::ATTEMPT_LIMIT_RST;
            force_defaults_reg <= 1'b0;
            bad_map_reg        <= '0;
            cur_sector_reg     <= 1'b0;
            cur_slot_reg       <= '0;
            tgt_sector_reg     <= 1'b0;
            tgt_slot_reg       <= '0;
            best_seq_reg       <= '0;
            found_valid_reg    <= 1'b0;
            record_seq_reg     <= '0;
            attempts_used_reg  <= '0;
            probes_used_reg    <= '0;
            fails_reg          <= '0;
            save_pending_reg   <= 1'b0;
            erase_reg          <= 1'b0;
        end
        else
        begin
            attempt_limit_reg  <= attempt_limit_next;
            force_defaults_reg <= force_defaults_next;
            bad_map_reg        <= bad_map_next;
            cur_sector_reg     <= cur_sector_next;
            cur_slot_reg       <= cur_slot_next;
            tgt_sector_reg     <= tgt_sector_next;
            tgt_slot_reg       <= tgt_slot_next;
            best_seq_reg       <= best_seq_next;
            found_valid_reg    <= found_valid_next;
            record_seq_reg     <= record_seq_next;
            attempts_used_reg  <= attempts_used_next;
            probes_used_reg    <= probes_used_next;
            fails_reg          <= fails_next;
            save_pending_reg   <= save_pending_next;
            erase_reg          <= erase_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_data;
        end
        if (cmd.out_load)
        begin
            out_data_reg <= res;
        end
    end

endmodule

>>> hw/rtl/flash_slot_rotation_manager_unit.sv
// Flash slot rotation manager: top level joining the controller and the datapath.
//
// Tracks record slots in two flash sectors used in turn. Every input transaction (scan
// report, scan done, save request, write outcome) yields exactly one result transaction.
// Items are handled one at a time; a save request or a failed write outcome walks the
// slots one probe per cycle, though the probe that ends the walk waits while the
// previous result is still stalled. Scan reports, scan done and write outcomes that
// commit or are ignored need no walk. The output register holds a finished result while
// the next input transaction is accepted; carrying out a captured item also waits while
// the previous result is stalled. Configuration writes (attempt limit, force defaults)
// go straight into their registers.
module flash_slot_rotation_manager_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  fsrm_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output fsrm_pkg::out_item_t                 out_data,
    input  logic                                cfg_wr_en,
    input  logic [fsrm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fsrm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    fsrm_pkg::cmd_t    cmd;
    fsrm_pkg::status_t status;

    fsrm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    fsrm_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

`ifndef SYNTH
    // one item at a time: an accepted transaction blocks the input next cycle
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted while an item is in work");

    a_program_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.kind == fsrm_pkg::KIND_PROGRAM)
        |-> (out_data.target_slot < fsrm_pkg::TSLOT_W'(fsrm_pkg::SLOTS)))
        else $error("program target outside the sector");

    a_erase_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.erase_first |-> (out_data.kind == fsrm_pkg::KIND_PROGRAM))
        else $error("erase request on a result that is not a program target");

    a_need_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.fresh_start |-> (out_data.kind == fsrm_pkg::KIND_SCAN_RESULT))
        else $error("fresh start flag on a result that is not a scan result");
`endif

endmodule
